### sv/mavlink_v1_frame_parser_assert.svh
// Assertion macros shared by the frame parser RTL.
// No dependencies; included by files that carry concurrent checks.
`ifndef MAVLINK_V1_FRAME_PARSER_ASSERT_SVH
`define MAVLINK_V1_FRAME_PARSER_ASSERT_SVH

// Same-cycle implication, disabled while reset is asserted.
`define MVP_ASSERT_IMPLY(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
		else $error("mvp assertion failed");

// Next-cycle implication, disabled while reset is asserted.
`define MVP_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
		else $error("mvp assertion failed");

`endif

### sv/mvp_pkg.sv
// Types, constants and CRC helpers for the MAVLink v1 frame parser.
// No dependencies; imported by every parser module.
`default_nettype none

package mvp_pkg;

	// Parse phases, one-hot
	typedef enum logic [8:0] {
		PH_HUNT    = 9'b000000001,
		PH_LEN     = 9'b000000010,
		PH_SEQ     = 9'b000000100,
		PH_SYS     = 9'b000001000,
		PH_COMP    = 9'b000010000,
		PH_MSG     = 9'b000100000,
		PH_PAYLOAD = 9'b001000000,
		PH_CK_LOW  = 9'b010000000,
		PH_CK_HIGH = 9'b100000000
	} phase_t;

	// Config register indexes
	localparam int unsigned CFG_IDX_W = 3;
	localparam logic [CFG_IDX_W-1:0] CFG_START_BYTE         = 3'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_EXTRA_HEARTBEAT    = 3'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_EXTRA_COMMAND_LONG = 3'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_EXTRA_COMMAND_ACK  = 3'd3;
	localparam logic [CFG_IDX_W-1:0] CFG_EXTRA_STATUS_TEXT  = 3'd4;
	localparam logic [CFG_IDX_W-1:0] CFG_EXTRA_ID_LIMIT     = 3'd5;
	localparam int unsigned CFG_DATA_W = 9;

	// Config reset values
	localparam logic [7:0] RST_START_BYTE         = 8'd254;
	localparam logic [7:0] RST_EXTRA_HEARTBEAT    = 8'd50;
	localparam logic [7:0] RST_EXTRA_COMMAND_LONG = 8'd152;
	localparam logic [7:0] RST_EXTRA_COMMAND_ACK  = 8'd143;
	localparam logic [7:0] RST_EXTRA_STATUS_TEXT  = 8'd83;
	localparam logic [8:0] RST_EXTRA_ID_LIMIT     = 9'd254;

	// Message ids with a configured extra byte
	localparam logic [7:0] MSG_HEARTBEAT    = 8'd0;
	localparam logic [7:0] MSG_COMMAND_LONG = 8'd76;
	localparam logic [7:0] MSG_COMMAND_ACK  = 8'd77;
	localparam logic [7:0] MSG_STATUS_TEXT  = 8'd253;

	// X.25 CRC, reflected
	localparam logic [15:0] CRC_INIT = 16'hFFFF;
	localparam logic [15:0] CRC_POLY = 16'h8408;

	typedef struct packed {
		logic [7:0] start_byte;
		logic [7:0] extra_heartbeat;
		logic [7:0] extra_command_long;
		logic [7:0] extra_command_ack;
		logic [7:0] extra_status_text;
		logic [8:0] extra_id_limit;
	} cfg_t;

	typedef struct packed {
		logic        payload_strobe;
		logic [7:0]  payload_index;
		logic [7:0]  payload_byte;
		logic        frame_end;
		logic        frame_good;
		logic [7:0]  frame_length;
		logic [7:0]  frame_sequence;
		logic [7:0]  source_system;
		logic [7:0]  source_component;
		logic [7:0]  message_id;
		logic [15:0] computed_checksum;
	} res_t;

	function automatic logic [15:0] crc_fold(input logic [15:0] crc, input logic [7:0] b);
		logic [15:0] c;
		c = crc ^ {8'h00, b};
		for (int k = 0; k < 8; k++) begin
			c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
		end
		return c;
	endfunction

	// Fold the per-message extra byte; ids at or above the limit fold nothing.
	function automatic logic [15:0] crc_finish(input logic [15:0] crc, input logic [7:0] id,
			input cfg_t cfg);
		logic [7:0] extra;
		extra = 8'h00;
		unique case (id)
			MSG_HEARTBEAT:    extra = cfg.extra_heartbeat;
			MSG_COMMAND_LONG: extra = cfg.extra_command_long;
			MSG_COMMAND_ACK:  extra = cfg.extra_command_ack;
			MSG_STATUS_TEXT:  extra = cfg.extra_status_text;
			default:          extra = 8'h00;
		endcase
		if ({1'b0, id} >= cfg.extra_id_limit) begin
			return crc;
		end
		return crc_fold(crc, extra);
	endfunction

endpackage

`default_nettype wire

### sv/mvp_cfg_regs.sv
// Configuration register file of the frame parser.
// Depends on mvp_pkg.
`default_nettype none

module mvp_cfg_regs
	import mvp_pkg::*;
(
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 cfg_we,
	input  wire logic [CFG_IDX_W-1:0] cfg_index,
	input  wire logic [CFG_DATA_W-1:0] cfg_wdata,
	output cfg_t                      cfg
);

	cfg_t cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.start_byte         <= RST_START_BYTE;
			cfg_q.extra_heartbeat    <= RST_EXTRA_HEARTBEAT;
			cfg_q.extra_command_long <= RST_EXTRA_COMMAND_LONG;
			cfg_q.extra_command_ack  <= RST_EXTRA_COMMAND_ACK;
			cfg_q.extra_status_text  <= RST_EXTRA_STATUS_TEXT;
			cfg_q.extra_id_limit     <= RST_EXTRA_ID_LIMIT;
		end else if (cfg_we) begin
			unique case (cfg_index)
				CFG_START_BYTE:         cfg_q.start_byte         <= cfg_wdata[7:0];
				CFG_EXTRA_HEARTBEAT:    cfg_q.extra_heartbeat    <= cfg_wdata[7:0];
				CFG_EXTRA_COMMAND_LONG: cfg_q.extra_command_long <= cfg_wdata[7:0];
				CFG_EXTRA_COMMAND_ACK:  cfg_q.extra_command_ack  <= cfg_wdata[7:0];
				CFG_EXTRA_STATUS_TEXT:  cfg_q.extra_status_text  <= cfg_wdata[7:0];
				CFG_EXTRA_ID_LIMIT:     cfg_q.extra_id_limit     <= cfg_wdata;
				default: ;
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

`default_nettype wire

### sv/mvp_frame_core.sv
// Phase sequencer, header capture and running CRC of the frame parser.
// Depends on mvp_pkg. Advances one byte per step.
`default_nettype none

module mvp_frame_core
	import mvp_pkg::*;
(
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       step,
	input  wire logic [7:0] rx_byte,
	input  wire cfg_t       cfg,
	output res_t            res
);

	phase_t      phase_q, phase_d;
	logic [15:0] crc_q, crc_d;
	logic [7:0]  len_q, len_d;
	logic [7:0]  seq_q, seq_d;
	logic [7:0]  sys_q, sys_d;
	logic [7:0]  comp_q, comp_d;
	logic [7:0]  msg_q, msg_d;
	logic [7:0]  count_q, count_d;
	logic [7:0]  ck_low_q, ck_low_d;
	logic [15:0] crc_byte;
	logic [15:0] calc;
	logic [7:0]  count_inc;
	logic        hunt_hit;

	assign crc_byte  = crc_fold(crc_q, rx_byte);
	// extra byte folded with the settings in force when the last checksum byte arrives
	assign calc      = crc_finish(crc_q, msg_q, cfg);
	assign count_inc = count_q + 8'd1;
	assign hunt_hit  = (rx_byte == cfg.start_byte);

	always_comb begin
		phase_d  = phase_q;
		crc_d    = crc_q;
		len_d    = len_q;
		seq_d    = seq_q;
		sys_d    = sys_q;
		comp_d   = comp_q;
		msg_d    = msg_q;
		count_d  = count_q;
		ck_low_d = ck_low_q;
		res      = '0;
		unique case (phase_q)
			PH_LEN: begin
				len_d   = rx_byte;
				count_d = 8'd0;
				crc_d   = crc_byte;
				phase_d = PH_SEQ;
			end
			PH_SEQ: begin
				seq_d   = rx_byte;
				crc_d   = crc_byte;
				phase_d = PH_SYS;
			end
			PH_SYS: begin
				sys_d   = rx_byte;
				crc_d   = crc_byte;
				phase_d = PH_COMP;
			end
			PH_COMP: begin
				comp_d  = rx_byte;
				crc_d   = crc_byte;
				phase_d = PH_MSG;
			end
			PH_MSG: begin
				msg_d   = rx_byte;
				crc_d   = crc_byte;
				phase_d = (len_q == 8'd0) ? PH_CK_LOW : PH_PAYLOAD;
			end
			PH_PAYLOAD: begin
				res.payload_strobe = 1'b1;
				res.payload_index  = count_q;
				res.payload_byte   = rx_byte;
				crc_d   = crc_byte;
				count_d = count_inc;
				if (count_inc >= len_q) begin
					phase_d = PH_CK_LOW;
				end
			end
			PH_CK_LOW: begin
				ck_low_d = rx_byte;
				phase_d  = PH_CK_HIGH;
			end
			PH_CK_HIGH: begin
				res.frame_end         = 1'b1;
				res.frame_good        = (calc == {rx_byte, ck_low_q});
				res.frame_length      = len_q;
				res.frame_sequence    = seq_q;
				res.source_system     = sys_q;
				res.source_component  = comp_q;
				res.message_id        = msg_q;
				res.computed_checksum = calc;
				phase_d = PH_HUNT;
			end
			PH_HUNT: begin
				phase_d = hunt_hit ? PH_LEN : PH_HUNT;
				if (hunt_hit) begin
					crc_d = CRC_INIT;
				end
			end
			default: begin
				phase_d = hunt_hit ? PH_LEN : PH_HUNT;
				if (hunt_hit) begin
					crc_d = CRC_INIT;
				end
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q  <= PH_HUNT;
			crc_q    <= CRC_INIT;
			len_q    <= '0;
			seq_q    <= '0;
			sys_q    <= '0;
			comp_q   <= '0;
			msg_q    <= '0;
			count_q  <= '0;
			ck_low_q <= '0;
		end else if (step) begin
			phase_q  <= phase_d;
			crc_q    <= crc_d;
			len_q    <= len_d;
			seq_q    <= seq_d;
			sys_q    <= sys_d;
			comp_q   <= comp_d;
			msg_q    <= msg_d;
			count_q  <= count_d;
			ck_low_q <= ck_low_d;
		end
	end

endmodule

`default_nettype wire

### sv/mavlink_v1_frame_parser.sv
// MAVLink v1 frame parser top level: input register, parse core, result register.
// Depends on mvp_pkg, mvp_cfg_regs, mvp_frame_core and the assertion macro header.
//
//   channel   | dir | request contents
//   ----------+-----+--------------------------------------------------------
//   s_axis    | in  | one received byte per request
//   m_axis    | out | one result per byte: payload byte, frame report or none
//   cfg       | in  | register write, index + data, no handshake
//
// One byte per cycle sustained while m_axis_tready stays high; an accepted byte
// passes through input register _s1, then core logic into result register _s2.
// The parse state advances only when the _s1 byte moves into _s2.
// A stalled result holds _s2; _s1 still takes a byte if it is empty, so a
// new request is taken while a finished result waits.
// arst_n clears both valid bits, the parse state (hunting) and the config
// registers to their defaults.
`default_nettype none
`include "mavlink_v1_frame_parser_assert.svh"

module mavlink_v1_frame_parser
	import mvp_pkg::*;
(
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	// rx_byte [7:0]
	input  wire logic                  s_axis_tvalid,
	output      logic                  s_axis_tready,
	input  wire logic [7:0]            s_axis_tdata,
	// payload_index [7:0], payload_byte [15:8], frame_good [16],
	// frame_length [24:17], frame_sequence [32:25], source_system [40:33],
	// source_component [48:41], message_id [56:49],
	// computed_checksum [72:57], zero fill [79:73]
	output      logic                  m_axis_tvalid,
	input  wire logic                  m_axis_tready,
	output      logic [79:0]           m_axis_tdata,
	// payload_strobe [0]
	output      logic                  m_axis_tuser,
	// frame_end
	output      logic                  m_axis_tlast,
	input  wire logic                  cfg_we,
	input  wire logic [CFG_IDX_W-1:0]  cfg_index,
	input  wire logic [CFG_DATA_W-1:0] cfg_wdata
);

	cfg_t       cfg;
	res_t       res;
	res_t       res_s2;
	logic       valid_s1;
	logic [7:0] byte_s1;
	logic       valid_s2;
	logic       adv_s1;

	// _s1 moves on when the result slot is empty or being drained
	assign adv_s1        = valid_s1 && (!valid_s2 || m_axis_tready);
	assign s_axis_tready = !valid_s1 || adv_s1;

	mvp_cfg_regs u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_wdata (cfg_wdata),
		.cfg       (cfg)
	);

	mvp_frame_core u_core (
		.clk     (clk),
		.arst_n  (arst_n),
		.step    (adv_s1),
		.rx_byte (byte_s1),
		.cfg     (cfg),
		.res     (res)
	);

	// Input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_axis_tready) begin
			valid_s1 <= s_axis_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_axis_tready && s_axis_tvalid) begin
			byte_s1 <= s_axis_tdata;
		end
	end

	// Result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (!valid_s2 || m_axis_tready) begin
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (adv_s1) begin
			res_s2 <= res;
		end
	end

	assign m_axis_tvalid = valid_s2;
	assign m_axis_tuser  = res_s2.payload_strobe;
	assign m_axis_tlast  = res_s2.frame_end;
	assign m_axis_tdata  = {7'd0,
		res_s2.computed_checksum,
		res_s2.message_id,
		res_s2.source_component,
		res_s2.source_system,
		res_s2.frame_sequence,
		res_s2.frame_length,
		res_s2.frame_good,
		res_s2.payload_byte,
		res_s2.payload_index};

	// A result is either a payload byte or a frame report, never both
	`MVP_ASSERT_IMPLY(a_kind_exclusive, clk, arst_n, m_axis_tvalid, !(m_axis_tuser && m_axis_tlast))
	// Frame report fields are zero away from frame end
	`MVP_ASSERT_IMPLY(a_report_zero, clk, arst_n, m_axis_tvalid && !m_axis_tlast, m_axis_tdata[72:16] == '0)
	// Payload fields are zero when the byte was not payload
	`MVP_ASSERT_IMPLY(a_payload_zero, clk, arst_n, m_axis_tvalid && !m_axis_tuser, m_axis_tdata[15:0] == '0)
	// A full pipe with a stalled output takes no new byte
	`MVP_ASSERT_IMPLY(a_full_stall, clk, arst_n, valid_s1 && valid_s2 && !m_axis_tready, !s_axis_tready)
	// An accepted byte always lands in the input register
	`MVP_ASSERT_NEXT(a_accept_lands, clk, arst_n, s_axis_tvalid && s_axis_tready, valid_s1)

endmodule

`default_nettype wire
